/* hdl/delta_patch_stream_decoder_macros.svh */
// assertion macros used by the checker of the patch stream decoder
`ifndef DELTA_PATCH_STREAM_DECODER_MACROS_SVH
`define DELTA_PATCH_STREAM_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpsd check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DPSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpsd check failed");

`endif

/* hdl/dpsd_pkg.sv */
// shared types, codes and tables of the patch stream decoder
package dpsd_pkg;

  // decode phase of the current patch
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_OPS,
    PH_LITERAL,
    PH_DONE
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_OLD_MD5 = 3'd0;
  localparam logic [2:0] KIND_NEW_MD5 = 3'd1;
  localparam logic [2:0] KIND_LITERAL = 3'd2;
  localparam logic [2:0] KIND_COPY    = 3'd3;
  localparam logic [2:0] KIND_OK      = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NOT_PATCH  = 3'd0;
  localparam logic [2:0] ERR_OLD_SIZE   = 3'd1;
  localparam logic [2:0] ERR_TRUNC_OP   = 3'd2;
  localparam logic [2:0] ERR_COPY_PAST  = 3'd3;
  localparam logic [2:0] ERR_TRUNC_DATA = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN_OP = 3'd5;
  localparam logic [2:0] ERR_OUT_SIZE   = 3'd6;

  // op kind bytes
  localparam logic [7:0] OP_COPY   = 8'd0;
  localparam logic [7:0] OP_INSERT = 8'd1;

  // default depth of the result queue
  localparam int unsigned RQ_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [4:0]  char_index;
    logic [31:0] copy_offset;
    logic [31:0] copy_length;
    logic [2:0]  error_code;
    logic        last_result;
  } res_t;

  // header magic "C3PATCH1"
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'h43;
      3'd1: v = 8'h33;
      3'd2: v = 8'h50;
      3'd3: v = 8'h41;
      3'd4: v = 8'h54;
      3'd5: v = 8'h43;
      3'd6: v = 8'h48;
      3'd7: v = 8'h31;
    endcase
    return v;
  endfunction

endpackage

/* hdl/delta_patch_stream_decoder.sv */
// top level of the copy/insert delta patch stream decoder
// results of an accepted patch byte are written into the registered result queue
// throughput: one patch byte per cycle; a byte that makes two results pushes
//   both into the queue, and in_ready drops while the result queue has
//   fewer than two free entries
// reset: synchronous active-low rst_n clears the phase, counters, the queue
//   and old_file_size; config writes are taken in every cycle outside reset
module delta_patch_stream_decoder #(
  parameter int unsigned RQ_DEPTH = dpsd_pkg::RQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_old_file_size,
  // patch byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_patch_byte,
  input  logic        in_final_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [4:0]  out_char_index,
  output logic [31:0] out_copy_offset,
  output logic [31:0] out_copy_length,
  output logic [2:0]  out_error_code,
  output logic        out_last_result
);

  // header byte map: magic, old size, old md5, new size, new md5, op count
  localparam logic [6:0] HDR_OLD_SIZE = 7'd8;
  localparam logic [6:0] HDR_OLD_MD5  = 7'd12;
  localparam logic [6:0] HDR_NEW_SIZE = 7'd44;
  localparam logic [6:0] HDR_NEW_MD5  = 7'd48;
  localparam logic [6:0] HDR_OPS      = 7'd80;
  localparam logic [6:0] HDR_LAST     = 7'd83;
  // op byte map: kind, first word, second word
  localparam logic [3:0] OP_W2        = 4'd5;
  localparam logic [3:0] OP_LAST      = 4'd8;

  // ---- state ----
  logic [31:0]       old_size_r;
  dpsd_pkg::phase_t  phase_r, ph_mid, phase_nxt;
  logic [6:0]        hdr_pos_r, hdr_pos_nxt;
  logic              magic_ok_r, magic_ok_now, magic_nxt;
  logic [31:0]       hdr_old_r, hdr_old_nxt;
  logic [31:0]       exp_new_r, exp_new_nxt;
  logic [31:0]       ops_rem_r, ops_rem_nxt;
  logic [7:0]        op_kind_r, op_kind_nxt;
  logic [31:0]       op_w1_r, op_w1_nxt;
  logic [31:0]       op_w2_r, op_w2_nxt;
  logic [3:0]        op_pos_r, op_pos_nxt;
  logic [31:0]       lit_rem_r, lit_rem_nxt;
  logic [63:0]       total_r, total_upd, total_nxt;

  // ---- decode conditions ----
  logic        acc, fin;
  logic        in_hdr, in_ops, in_lit;
  logic        hdr_last, hdr_err_magic, hdr_err_size, hdr_ok;
  logic        md5_old, md5_new;
  logic [6:0]  old_idx, new_idx;
  logic [1:0]  op_lane;
  logic        op_last, is_copy, is_ins, bad_kind;
  logic [32:0] copy_end;
  logic        copy_bad, copy_ok, ins_empty, ins_long;
  logic        lit_last, op_complete, end_now, end_good, stop;

  // ---- results ----
  dpsd_pkg::res_t res_p, res_e, res_f, slot0, slot1;
  logic           p_v, e_v, f_v;
  logic [1:0]     n_res, push_cnt;
  logic           q_room, q_pop;
  dpsd_pkg::res_t q_head;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid & in_ready;
  assign fin       = in_final_byte;

  assign in_hdr = (phase_r == dpsd_pkg::PH_HEADER);
  assign in_ops = (phase_r == dpsd_pkg::PH_OPS);
  assign in_lit = (phase_r == dpsd_pkg::PH_LITERAL);

  // header: magic and old size are judged on the last header byte
  assign hdr_last      = in_hdr && (hdr_pos_r == HDR_LAST);
  assign hdr_err_magic = hdr_last && !magic_ok_r;
  assign hdr_err_size  = hdr_last && magic_ok_r && (hdr_old_r != old_size_r);
  assign hdr_ok        = hdr_last && magic_ok_r && (hdr_old_r == old_size_r);
  assign magic_ok_now  = (in_hdr && (hdr_pos_r < HDR_OLD_SIZE)) ?
                         (magic_ok_r && (in_patch_byte == dpsd_pkg::magic_byte(hdr_pos_r[2:0]))) :
                         magic_ok_r;

  assign md5_old = in_hdr && (hdr_pos_r >= HDR_OLD_MD5) && (hdr_pos_r < HDR_NEW_SIZE);
  assign md5_new = in_hdr && (hdr_pos_r >= HDR_NEW_MD5) && (hdr_pos_r < HDR_OPS);
  assign old_idx = hdr_pos_r - HDR_OLD_MD5;
  assign new_idx = hdr_pos_r - HDR_NEW_MD5;

  // both op words start on a byte position one above a multiple of four
  assign op_lane = op_pos_r[1:0] - 2'd1;

  // ---- field capture: header and op fields are written byte lane by byte lane ----
  always_comb begin
    hdr_old_nxt = hdr_old_r;
    exp_new_nxt = exp_new_r;
    ops_rem_nxt = ops_rem_r;
    op_kind_nxt = op_kind_r;
    op_w1_nxt   = op_w1_r;
    op_w2_nxt   = op_w2_r;
    lit_rem_nxt = lit_rem_r;
    if (in_hdr) begin
      // the size fields all start on multiples of four
      if ((hdr_pos_r >= HDR_OLD_SIZE) && (hdr_pos_r < HDR_OLD_MD5)) begin
        hdr_old_nxt[{hdr_pos_r[1:0], 3'b000} +: 8] = in_patch_byte;
      end
      if ((hdr_pos_r >= HDR_NEW_SIZE) && (hdr_pos_r < HDR_NEW_MD5)) begin
        exp_new_nxt[{hdr_pos_r[1:0], 3'b000} +: 8] = in_patch_byte;
      end
      if (hdr_pos_r >= HDR_OPS) begin
        ops_rem_nxt[{hdr_pos_r[1:0], 3'b000} +: 8] = in_patch_byte;
      end
    end else if (in_ops) begin
      if (op_pos_r == 4'd0) begin
        op_kind_nxt = in_patch_byte;
      end else if (op_pos_r < OP_W2) begin
        op_w1_nxt[{op_lane, 3'b000} +: 8] = in_patch_byte;
      end else begin
        op_w2_nxt[{op_lane, 3'b000} +: 8] = in_patch_byte;
      end
      if (op_pos_r == OP_LAST) begin
        ops_rem_nxt = ops_rem_r - 32'd1;
        if (op_kind_r == dpsd_pkg::OP_INSERT) begin
          lit_rem_nxt = op_w1_r;
        end
      end
    end else if (in_lit) begin
      lit_rem_nxt = lit_rem_r - 32'd1;
    end
  end

  // ---- op judgment on the ninth byte ----
  assign op_last   = in_ops && (op_pos_r == OP_LAST);
  assign is_copy   = op_last && (op_kind_r == dpsd_pkg::OP_COPY);
  assign is_ins    = op_last && (op_kind_r == dpsd_pkg::OP_INSERT);
  assign bad_kind  = op_last && !is_copy && !is_ins;
  // bounds check at full precision: offset + length may carry out of 32 bits
  assign copy_end  = {1'b0, op_w1_r} + {1'b0, op_w2_nxt};
  assign copy_bad  = is_copy && (copy_end > {1'b0, old_size_r});
  assign copy_ok   = is_copy && !copy_bad;
  assign ins_empty = is_ins && (op_w1_r == 32'd0);
  assign ins_long  = is_ins && (op_w1_r != 32'd0);
  assign lit_last  = in_lit && (lit_rem_r == 32'd1);

  // an op (or the header) has finished cleanly; end report when none are left
  assign op_complete = hdr_ok || copy_ok || ins_empty || lit_last;
  assign end_now     = op_complete && (ops_rem_nxt == 32'd0);

  // running output byte count
  always_comb begin
    total_upd = total_r;
    if (copy_ok) begin
      total_upd = total_r + {32'd0, op_w2_nxt};
    end else if (in_lit) begin
      total_upd = total_r + 64'd1;
    end
  end

  assign end_good  = (total_upd == {32'd0, exp_new_nxt});
  assign stop      = hdr_err_magic || hdr_err_size || copy_bad || bad_kind || end_now;

  // ---- next phase ----
  always_comb begin
    ph_mid = phase_r;
    if (stop) begin
      ph_mid = dpsd_pkg::PH_DONE;
    end else if (op_complete) begin
      ph_mid = dpsd_pkg::PH_OPS;
    end else if (ins_long) begin
      ph_mid = dpsd_pkg::PH_LITERAL;
    end
    // the final byte always starts a fresh patch
    phase_nxt = fin ? dpsd_pkg::PH_HEADER : ph_mid;
  end

  // ---- counters and flags ----
  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    op_pos_nxt  = op_pos_r;
    if (in_hdr && !hdr_last) begin
      hdr_pos_nxt = hdr_pos_r + 7'd1;
    end
    if (in_ops) begin
      op_pos_nxt = op_last ? 4'd0 : op_pos_r + 4'd1;
    end
    magic_nxt = magic_ok_now;
    total_nxt = total_upd;
    if (fin) begin
      hdr_pos_nxt = '0;
      op_pos_nxt  = '0;
      magic_nxt   = 1'b1;
      total_nxt   = '0;
    end
  end

  // ---- results for this byte: primary, end report, early-final error ----
  always_comb begin
    res_p = '0;
    p_v   = 1'b0;
    if (md5_old) begin
      p_v              = 1'b1;
      res_p.kind       = dpsd_pkg::KIND_OLD_MD5;
      res_p.data_byte  = in_patch_byte;
      res_p.char_index = old_idx[4:0];
    end else if (md5_new) begin
      p_v              = 1'b1;
      res_p.kind       = dpsd_pkg::KIND_NEW_MD5;
      res_p.data_byte  = in_patch_byte;
      res_p.char_index = new_idx[4:0];
    end else if (hdr_err_magic) begin
      p_v              = 1'b1;
      res_p.kind       = dpsd_pkg::KIND_ERROR;
      res_p.error_code = dpsd_pkg::ERR_NOT_PATCH;
    end else if (hdr_err_size) begin
      p_v              = 1'b1;
      res_p.kind       = dpsd_pkg::KIND_ERROR;
      res_p.error_code = dpsd_pkg::ERR_OLD_SIZE;
    end else if (copy_bad) begin
      p_v              = 1'b1;
      res_p.kind       = dpsd_pkg::KIND_ERROR;
      res_p.error_code = dpsd_pkg::ERR_COPY_PAST;
    end else if (bad_kind) begin
      p_v              = 1'b1;
      res_p.kind       = dpsd_pkg::KIND_ERROR;
      res_p.error_code = dpsd_pkg::ERR_UNKNOWN_OP;
    end else if (copy_ok) begin
      p_v               = 1'b1;
      res_p.kind        = dpsd_pkg::KIND_COPY;
      res_p.copy_offset = op_w1_r;
      res_p.copy_length = op_w2_nxt;
    end else if (in_lit) begin
      p_v             = 1'b1;
      res_p.kind      = dpsd_pkg::KIND_LITERAL;
      res_p.data_byte = in_patch_byte;
    end

    res_e            = '0;
    e_v              = end_now;
    res_e.kind       = end_good ? dpsd_pkg::KIND_OK : dpsd_pkg::KIND_ERROR;
    res_e.error_code = end_good ? dpsd_pkg::ERR_NOT_PATCH : dpsd_pkg::ERR_OUT_SIZE;

    // final byte before the patch ended: error by where decoding stopped
    res_f      = '0;
    res_f.kind = dpsd_pkg::KIND_ERROR;
    f_v        = fin && (ph_mid != dpsd_pkg::PH_DONE);
    unique case (ph_mid)
      dpsd_pkg::PH_HEADER:  res_f.error_code = dpsd_pkg::ERR_NOT_PATCH;
      dpsd_pkg::PH_OPS:     res_f.error_code = dpsd_pkg::ERR_TRUNC_OP;
      dpsd_pkg::PH_LITERAL: res_f.error_code = dpsd_pkg::ERR_TRUNC_DATA;
      dpsd_pkg::PH_DONE:    res_f.error_code = dpsd_pkg::ERR_NOT_PATCH;
    endcase

    // at most two of the three are present; pack them in order
    n_res = {1'b0, p_v} + {1'b0, e_v} + {1'b0, f_v};
    slot0 = p_v ? res_p : (e_v ? res_e : res_f);
    slot1 = (p_v && e_v) ? res_e : res_f;
    slot0.last_result = (n_res == 2'd1);
    slot1.last_result = 1'b1;
    push_cnt = acc ? n_res : 2'd0;
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_size_r <= '0;
      phase_r    <= dpsd_pkg::PH_HEADER;
      hdr_pos_r  <= '0;
      op_pos_r   <= '0;
      magic_ok_r <= 1'b1;
      total_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        old_size_r <= cfg_old_file_size;
      end
      if (acc) begin
        phase_r    <= phase_nxt;
        hdr_pos_r  <= hdr_pos_nxt;
        op_pos_r   <= op_pos_nxt;
        magic_ok_r <= magic_nxt;
        total_r    <= total_nxt;
      end
    end
  end

  // captured fields are always written before they are read
  always_ff @(posedge clk) begin
    if (acc) begin
      hdr_old_r <= hdr_old_nxt;
      exp_new_r <= exp_new_nxt;
      ops_rem_r <= ops_rem_nxt;
      op_kind_r <= op_kind_nxt;
      op_w1_r   <= op_w1_nxt;
      op_w2_r   <= op_w2_nxt;
      lit_rem_r <= lit_rem_nxt;
    end
  end

  // ---- result queue decouples the byte side from the result side ----
  assign q_pop = out_valid && out_ready;

  dpsd_rq #(
    .DEPTH (RQ_DEPTH)
  ) u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (slot0),
    .push_d1   (slot1),
    .room      (q_room),
    .pop       (q_pop),
    .not_empty (out_valid),
    .head      (q_head)
  );

  // a byte is taken only when two results fit
  assign in_ready = q_room;

  assign out_kind        = q_head.kind;
  assign out_data_byte   = q_head.data_byte;
  assign out_char_index  = q_head.char_index;
  assign out_copy_offset = q_head.copy_offset;
  assign out_copy_length = q_head.copy_length;
  assign out_error_code  = q_head.error_code;
  assign out_last_result = q_head.last_result;

endmodule

/* hdl/dpsd_rq.sv */
// result queue: takes up to two results per cycle, hands out one per cycle
module dpsd_rq #(
  parameter int unsigned DEPTH = dpsd_pkg::RQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  dpsd_pkg::res_t   push_d0,
  input  dpsd_pkg::res_t   push_d1,
  output logic             room,
  input  logic             pop,
  output logic             not_empty,
  output dpsd_pkg::res_t   head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dpsd_pkg::res_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r, wr_nxt, rd_nxt, wr_second;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_second = ptr_inc(wr_r);
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    if (push_cnt == 2'd1) begin
      wr_nxt = wr_second;
    end else if (push_cnt == 2'd2) begin
      wr_nxt = ptr_inc(wr_second);
    end
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_second] <= push_d1;
    end
  end

endmodule

/* hdl/dpsd_chk.sv */
// port-level checker for the patch stream decoder, bound to the top level
`include "delta_patch_stream_decoder_macros.svh"

module dpsd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] cfg_old_file_size,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_patch_byte,
  input logic        in_final_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [4:0]  out_char_index,
  input logic [31:0] out_copy_offset,
  input logic [31:0] out_copy_length,
  input logic [2:0]  out_error_code,
  input logic        out_last_result
);

  // a stalled result stays valid and keeps its kind, data byte and copy length
  `DPSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data_byte) && $stable(out_copy_length))

  // only error results carry an error code
  `DPSD_ASSERT_IMP(a_err_code_zero, out_valid && (out_kind != dpsd_pkg::KIND_ERROR), out_error_code == 3'd0)

  // an end report or error always closes the results of its byte
  `DPSD_ASSERT_IMP(a_report_last, out_valid && ((out_kind == dpsd_pkg::KIND_OK) || (out_kind == dpsd_pkg::KIND_ERROR)), out_last_result)

  // copy fields are zero outside copy commands
  `DPSD_ASSERT_IMP(a_copy_fields, out_valid && (out_kind != dpsd_pkg::KIND_COPY), (out_copy_offset == 32'd0) && (out_copy_length == 32'd0))

endmodule

bind delta_patch_stream_decoder dpsd_chk u_dpsd_chk (.*);

/* dv/delta_patch_stream_decoder_tb.sv */
// self-checking testbench for the delta patch stream decoder
`timescale 1ns / 100ps

module delta_patch_stream_decoder_tb;

  // header magic, first byte in the top lane
  localparam logic [63:0] PATCH_MAGIC = 64'h43_33_50_41_54_43_48_31;
  // header byte holding the last op count byte
  localparam int unsigned HDR_LAST = 83;
  // cycles to let the block settle once nothing more is predicted
  localparam int unsigned DRAIN_CYCLES = 8;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned LONG_HOLD = 80;
  // random patch bytes per register setting
  localparam int unsigned BYTES_PER_SETTING = 40;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_old_file_size;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_patch_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [4:0]  out_char_index;
  logic [31:0] out_copy_offset;
  logic [31:0] out_copy_length;
  logic [2:0]  out_error_code;
  logic        out_last_result;

  delta_patch_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_old_file_size(cfg_old_file_size),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_patch_byte    (in_patch_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_char_index   (out_char_index),
    .out_copy_offset  (out_copy_offset),
    .out_copy_length  (out_copy_length),
    .out_error_code   (out_error_code),
    .out_last_result  (out_last_result)
  );

  // ---------------------------------------------------------------------------
  // decode predictor and result checker
  // ---------------------------------------------------------------------------
  class decode_scoreboard;
    dpsd_pkg::res_t   predicted_results[$];
    dpsd_pkg::res_t   step_results[$];
    int unsigned      failures;
    // register copy
    logic [31:0]      old_file_size;
    // per-patch decode state
    dpsd_pkg::phase_t ph;
    int unsigned      hdr_pos;
    bit               magic_ok;
    logic [31:0]      hdr_old_size;
    logic [31:0]      new_size;
    logic [31:0]      ops_left;
    logic [7:0]       op_code;
    logic [31:0]      first_word;
    logic [31:0]      second_word;
    int unsigned      op_pos;
    logic [31:0]      lit_left;
    logic [63:0]      out_total;

    function new();
      failures = 0;
      old_file_size = '0;
      clear_patch();
    endfunction

    function void clear_patch();
      ph = dpsd_pkg::PH_HEADER;
      hdr_pos = 0;
      magic_ok = 1'b1;
      hdr_old_size = '0;
      new_size = '0;
      ops_left = '0;
      op_code = '0;
      first_word = '0;
      second_word = '0;
      op_pos = 0;
      lit_left = '0;
      out_total = '0;
    endfunction

    function void add(logic [2:0] kind, logic [7:0] data, logic [4:0] idx,
                      logic [31:0] off, logic [31:0] len);
      dpsd_pkg::res_t r;
      r = '0;
      r.kind = kind;
      r.data_byte = data;
      r.char_index = idx;
      r.copy_offset = off;
      r.copy_length = len;
      step_results.insert(step_results.size(), r);
    endfunction

    // any error ends the patch until its final byte
    function void abort(logic [2:0] code);
      ph = dpsd_pkg::PH_DONE;
      add(dpsd_pkg::KIND_ERROR, '0, '0, '0, '0);
      step_results[step_results.size() - 1].error_code = code;
    endfunction

    function void end_report();
      if (out_total == {32'h0, new_size}) begin
        ph = dpsd_pkg::PH_DONE;
        add(dpsd_pkg::KIND_OK, '0, '0, '0, '0);
      end else begin
        abort(dpsd_pkg::ERR_OUT_SIZE);
      end
    endfunction

    function void op_finished();
      ph = dpsd_pkg::PH_OPS;
      if (ops_left == 0) end_report();
    endfunction

    function void header_byte(logic [7:0] b);
      if (hdr_pos < 8) begin
        if (b != PATCH_MAGIC[63 - 8*hdr_pos -: 8]) magic_ok = 1'b0;
      end else if (hdr_pos < 12) begin
        hdr_old_size[8*(hdr_pos - 8) +: 8] = b;
      end else if (hdr_pos < 44) begin
        add(dpsd_pkg::KIND_OLD_MD5, b, 5'(hdr_pos - 12), '0, '0);
      end else if (hdr_pos < 48) begin
        new_size[8*(hdr_pos - 44) +: 8] = b;
      end else if (hdr_pos < 80) begin
        add(dpsd_pkg::KIND_NEW_MD5, b, 5'(hdr_pos - 48), '0, '0);
      end else begin
        ops_left[8*(hdr_pos - 80) +: 8] = b;
      end
      if (hdr_pos >= HDR_LAST) begin
        // magic is judged before the old size
        if (!magic_ok) abort(dpsd_pkg::ERR_NOT_PATCH);
        else if (hdr_old_size != old_file_size) abort(dpsd_pkg::ERR_OLD_SIZE);
        else op_finished();
      end else begin
        hdr_pos++;
      end
    endfunction

    function void op_byte(logic [7:0] b);
      if (op_pos == 0) begin
        op_code = b;
        first_word = '0;
        second_word = '0;
      end else if (op_pos < 5) begin
        first_word[8*(op_pos - 1) +: 8] = b;
      end else begin
        second_word[8*(op_pos - 5) +: 8] = b;
      end
      if (op_pos < 8) begin
        op_pos++;
        return;
      end
      op_pos = 0;
      ops_left = ops_left - 1;
      if (op_code == dpsd_pkg::OP_COPY) begin
        // bounds check at full precision, no wrap of offset plus length
        if ({32'h0, first_word} + {32'h0, second_word} > {32'h0, old_file_size}) begin
          abort(dpsd_pkg::ERR_COPY_PAST);
        end else begin
          add(dpsd_pkg::KIND_COPY, '0, '0, first_word, second_word);
          out_total = out_total + {32'h0, second_word};
          op_finished();
        end
      end else if (op_code == dpsd_pkg::OP_INSERT) begin
        lit_left = first_word;
        if (lit_left == 0) op_finished();
        else ph = dpsd_pkg::PH_LITERAL;
      end else begin
        abort(dpsd_pkg::ERR_UNKNOWN_OP);
      end
    endfunction

    // predict everything one accepted patch byte causes
    function void take_patch_byte(logic [7:0] b, logic fin);
      step_results.delete();
      case (ph)
        dpsd_pkg::PH_HEADER: header_byte(b);
        dpsd_pkg::PH_OPS:    op_byte(b);
        dpsd_pkg::PH_LITERAL: begin
          add(dpsd_pkg::KIND_LITERAL, b, '0, '0, '0);
          out_total = out_total + 64'd1;
          lit_left = lit_left - 1;
          if (lit_left == 0) op_finished();
        end
        default: ;
      endcase
      // an early final byte closes the patch with an error after its own results
      if (fin) begin
        case (ph)
          dpsd_pkg::PH_HEADER:  abort(dpsd_pkg::ERR_NOT_PATCH);
          dpsd_pkg::PH_OPS:     abort(dpsd_pkg::ERR_TRUNC_OP);
          dpsd_pkg::PH_LITERAL: abort(dpsd_pkg::ERR_TRUNC_DATA);
          default: ;
        endcase
        clear_patch();
      end
      if (step_results.size() > 0) begin
        step_results[step_results.size() - 1].last_result = 1'b1;
      end
      foreach (step_results[i]) begin
        predicted_results.insert(predicted_results.size(), step_results[i]);
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_decoded(dpsd_pkg::res_t got);
      dpsd_pkg::res_t want;
      if (predicted_results.size() == 0) begin
        $error("result with nothing predicted: kind %0d", got.kind);
        failures++;
        return;
      end
      want = predicted_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("data_byte", want.data_byte, got.data_byte);
      compare("char_index", want.char_index, got.char_index);
      compare("copy_offset", want.copy_offset, got.copy_offset);
      compare("copy_length", want.copy_length, got.copy_length);
      compare("error_code", want.error_code, got.error_code);
      compare("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  decode_scoreboard sb;
  bit               sender_calm;
  bit               receiver_calm;
  int unsigned      bytes_sent;

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one patch byte and hold it until accepted; valid only drops on a gap
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_patch_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    sb.take_patch_byte(b, fin);
    bytes_sent++;
  endtask

  // stop offering and let every predicted result come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk);
    // a byte with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_old_size(input logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_old_file_size <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.old_file_size = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_word(ref logic [7:0] pb[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) pb.insert(pb.size(), w[8*i +: 8]);
  endtask

  // build one patch, mostly well formed, and send it with its final byte
  task automatic send_patch(input logic [31:0] old_sz);
    logic [7:0]  pb[$];
    logic [7:0]  ops[$];
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] hdr_old;
    logic [31:0] new_sz;
    logic [31:0] op_count;
    logic [63:0] produced;
    int unsigned n_ops;
    int unsigned lit_len;
    int unsigned cut;
    sender_calm = ($urandom_range(0, 3) == 0);
    produced = '0;
    if ($urandom_range(0, 9) == 0) begin
      // plain noise, nearly always a bad header
      repeat ($urandom_range(1, 20)) pb.insert(pb.size(), 8'($urandom));
    end else begin
      n_ops = $urandom_range(0, 6);
      for (int k = 0; k < n_ops; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            case ($urandom_range(0, 5))
              0: begin off = old_sz; len = '0; end           // ends exactly at the end
              1: begin off = '0; len = old_sz; end           // whole old file
              2: begin off = old_sz; len = 32'd1; end        // one byte past the end
              3: begin off = $urandom; len = $urandom; end   // mostly out of bounds
              default: begin
                off = $urandom_range(0, old_sz);
                len = $urandom_range(0, old_sz - off);
              end
            endcase
            ops.insert(ops.size(), dpsd_pkg::OP_COPY);
            push_word(ops, off);
            push_word(ops, len);
            produced = produced + {32'h0, len};
          end
          10, 11, 12, 13, 14, 15, 16, 17: begin
            lit_len = $urandom_range(0, 5);
            ops.insert(ops.size(), dpsd_pkg::OP_INSERT);
            push_word(ops, lit_len);
            push_word(ops, $urandom);
            repeat (lit_len) ops.insert(ops.size(), 8'($urandom));
            produced = produced + lit_len;
          end
          default: begin
            // kind byte that is neither copy nor insert
            ops.insert(ops.size(),
                       ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(2, 254)));
            push_word(ops, $urandom);
            push_word(ops, $urandom);
          end
        endcase
      end

      hdr_old = old_sz;
      if ($urandom_range(0, 6) == 0) hdr_old = old_sz ^ (32'h1 << $urandom_range(0, 31));
      case ($urandom_range(0, 7))
        0: new_sz = produced[31:0] + 32'd1;
        1: new_sz = $urandom;
        default: new_sz = produced[31:0];
      endcase
      case ($urandom_range(0, 11))
        0: op_count = n_ops + $urandom_range(1, 2);          // patch runs short
        1: op_count = (n_ops == 0) ? 32'd0 : n_ops - 1;      // trailing ops ignored
        2: op_count = 32'hFFFF_FFFF;
        default: op_count = n_ops;
      endcase

      for (int i = 0; i < 8; i++) pb.insert(pb.size(), PATCH_MAGIC[63 - 8*i -: 8]);
      if ($urandom_range(0, 9) == 0) begin
        pb[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
      end
      push_word(pb, hdr_old);
      repeat (32) pb.insert(pb.size(), 8'($urandom));
      push_word(pb, new_sz);
      repeat (32) pb.insert(pb.size(), 8'($urandom));
      push_word(pb, op_count);
      foreach (ops[i]) pb.insert(pb.size(), ops[i]);

      // junk after the end report
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) pb.insert(pb.size(), 8'($urandom));
      end
      // cut anywhere: inside the header, an op or the literal bytes
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, pb.size());
        pb = pb[0:cut-1];
      end
    end
    foreach (pb[i]) send_byte(pb[i], i == pb.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, calm stretches and two long hold-offs
  // ---------------------------------------------------------------------------
  initial begin
    dpsd_pkg::res_t got;
    int unsigned    taken;
    int unsigned    hold;
    out_ready <= 1'b0;
    taken = 0;
    receiver_calm = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken % 32 == 0 && $urandom_range(0, 2) == 0) receiver_calm = ~receiver_calm;
      if (taken == 100 || taken == 600) hold = LONG_HOLD;
      else hold = receiver_calm ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind = out_kind;
      got.data_byte = out_data_byte;
      got.char_index = out_char_index;
      got.copy_offset = out_copy_offset;
      got.copy_length = out_copy_length;
      got.error_code = out_error_code;
      got.last_result = out_last_result;
      sb.check_decoded(got);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] size_plan[6];
    int unsigned start_count;
    sb = new();
    bytes_sent = 0;
    sender_calm = 1'b0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_old_file_size <= '0;
    in_valid <= 1'b0;
    in_patch_byte <= '0;
    in_final_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: final byte inside the header, old size register at its reset value
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);
    for (int i = 0; i < 5; i++) send_byte(PATCH_MAGIC[63 - 8*i -: 8], i == 4);
    for (int i = 0; i < 8; i++) send_byte(PATCH_MAGIC[63 - 8*i -: 8], 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);

    // random patches under several old sizes, extremes first
    size_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'($urandom_range(2, 4096)), $urandom, 32'($urandom_range(100, 1000))};
    foreach (size_plan[s]) begin
      write_old_size(size_plan[s]);
      start_count = bytes_sent;
      while (bytes_sent - start_count < BYTES_PER_SETTING) begin
        send_patch(size_plan[s]);
        // now and then hold the input until the output side has caught up
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
    end

    wait_drained();
    if (sb.failures == 0 && sb.predicted_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
